### hdl/ppd_pkg.sv
// Shared constants and types of the primary ray direction pipeline.
`default_nettype none
package ppd_pkg;
    localparam int COORD_BITS = 16;
    localparam int DIR_BITS   = 16;
    localparam int COMP_BITS  = 16;
    localparam int CFG_W      = 3 * COMP_BITS;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] IDX_RIGHT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] IDX_UP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] IDX_FWD   = 2'd2;

    localparam int PROD_W = COORD_BITS + COMP_BITS;
    localparam int SUM_W  = PROD_W + 2;
    localparam int LZ_W   = $clog2(SUM_W + 1);
    localparam int MAG_W  = 30;
    localparam int SQ_W   = 2 * MAG_W + 2;
    localparam int RW     = SQ_W + 1;
    localparam int ROOT_W = MAG_W + 1;
    localparam int QB     = DIR_BITS + 1;
    localparam int NUM_W  = ROOT_W + QB;

    localparam int FRONT_LAT = 7;
    localparam int SQRT_LAT  = ROOT_W;
    localparam int DIV_LAT   = QB + 1;
    localparam int LAT       = FRONT_LAT + SQRT_LAT + DIV_LAT + 1;

    typedef logic [2:0][MAG_W-1:0] mag3_t;
    typedef logic [2:0][QB-1:0]    quo3_t;

    typedef struct packed {
        logic [2:0] neg;
        logic       degen;
    } side_t;
endpackage
`default_nettype wire

### hdl/ppd_front.sv
// Front end: basis products, sums, magnitudes, normalisation and sum of squares.
`default_nettype none
module ppd_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic signed [ppd_pkg::COORD_BITS-1:0] u,
    input  wire logic signed [ppd_pkg::COORD_BITS-1:0] v,
    input  wire logic [ppd_pkg::CFG_W-1:0]     right_cfg,
    input  wire logic [ppd_pkg::CFG_W-1:0]     up_cfg,
    input  wire logic [ppd_pkg::CFG_W-1:0]     fwd_cfg,
    output logic                               out_valid,
    output ppd_pkg::mag3_t                     mag,
    output logic [ppd_pkg::SQ_W-1:0]           sumsq,
    output ppd_pkg::side_t                     side
);
    import ppd_pkg::*;

    logic [FRONT_LAT-1:0] vld_reg;

    logic signed [PROD_W-1:0]    pu_reg [3];
    logic signed [PROD_W-1:0]    pv_reg [3];
    logic signed [COMP_BITS-1:0] f_reg  [3];

    logic [SUM_W-1:0] m2_reg [3];
    logic [2:0]       neg2_reg;

    logic [SUM_W-1:0] m3_reg [3];
    logic [SUM_W-1:0] max3_reg;
    logic [2:0]       neg3_reg;

    logic [SUM_W-1:0] m4_reg [3];
    logic [LZ_W-1:0]  lz4_reg;
    logic [2:0]       neg4_reg;
    logic             degen4_reg;

    mag3_t            m5_reg;
    logic [2:0]       neg5_reg;
    logic             degen5_reg;

    logic [2*MAG_W-1:0] sq6_reg [3];
    mag3_t              m6_reg;
    logic [2:0]         neg6_reg;
    logic               degen6_reg;

    mag3_t              m7_reg;
    logic [SQ_W-1:0]    sumsq7_reg;
    logic [2:0]         neg7_reg;
    logic               degen7_reg;

    logic signed [SUM_W-1:0] s_next [3];
    logic [SUM_W-1:0]        max_next;
    logic [LZ_W-1:0]         lz_next;
    mag3_t                   nm_next;
    logic [SUM_W+MAG_W-1:0]  wide;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s_next[i] = SUM_W'(pu_reg[i]) + SUM_W'(pv_reg[i])
                      + (SUM_W'(f_reg[i]) <<< (COORD_BITS - 1));
        end
        max_next = m2_reg[0];
        if (m2_reg[1] > max_next)
        begin
            max_next = m2_reg[1];
        end
        if (m2_reg[2] > max_next)
        begin
            max_next = m2_reg[2];
        end
        lz_next = LZ_W'(SUM_W);
        for (int b = 0; b < SUM_W; b++)
        begin
            if (max3_reg[b])
            begin
                lz_next = LZ_W'(SUM_W - 1 - b);
            end
        end
        wide = '0;
        for (int i = 0; i < 3; i++)
        begin
            wide = {m4_reg[i], {MAG_W{1'b0}}} << lz4_reg;
            nm_next[i] = wide[SUM_W+MAG_W-1 -: MAG_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[FRONT_LAT-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            pu_reg[i] <= u * $signed(right_cfg[COMP_BITS*i +: COMP_BITS]);
            pv_reg[i] <= v * $signed(up_cfg[COMP_BITS*i +: COMP_BITS]);
            f_reg[i]  <= $signed(fwd_cfg[COMP_BITS*i +: COMP_BITS]);
            neg2_reg[i] <= s_next[i][SUM_W-1];
            m2_reg[i]   <= s_next[i][SUM_W-1] ? SUM_W'(-s_next[i]) : SUM_W'(s_next[i]);
            m3_reg[i] <= m2_reg[i];
            m4_reg[i] <= m3_reg[i];
            sq6_reg[i] <= m5_reg[i] * m5_reg[i];
        end
        neg3_reg   <= neg2_reg;
        max3_reg   <= max_next;
        neg4_reg   <= neg3_reg;
        lz4_reg    <= lz_next;
        degen4_reg <= (max3_reg == '0);
        m5_reg     <= nm_next;
        neg5_reg   <= neg4_reg;
        degen5_reg <= degen4_reg;
        m6_reg     <= m5_reg;
        neg6_reg   <= neg5_reg;
        degen6_reg <= degen5_reg;
        m7_reg     <= m6_reg;
        sumsq7_reg <= SQ_W'(sq6_reg[0]) + SQ_W'(sq6_reg[1]) + SQ_W'(sq6_reg[2]);
        neg7_reg   <= neg6_reg;
        degen7_reg <= degen6_reg;
    end

    assign out_valid  = vld_reg[FRONT_LAT-1];
    assign mag        = m7_reg;
    assign sumsq      = sumsq7_reg;
    assign side.neg   = neg7_reg;
    assign side.degen = degen7_reg;
endmodule
`default_nettype wire

### hdl/ppd_sqrt.sv
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module ppd_sqrt (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    input  wire logic [ppd_pkg::SQ_W-1:0] x,
    input  ppd_pkg::mag3_t                in_mag,
    input  ppd_pkg::side_t                in_side,
    output logic                          out_valid,
    output logic [ppd_pkg::ROOT_W-1:0]    root,
    output ppd_pkg::mag3_t                out_mag,
    output ppd_pkg::side_t                out_side
);
    import ppd_pkg::*;

    localparam int N = SQRT_LAT;

    logic [N-1:0]  vld_reg;
    logic [RW-1:0] x_reg   [N];
    logic [RW-1:0] res_reg [N];
    mag3_t         mag_reg [N];
    side_t         side_reg[N];

    logic [RW-1:0] x_next   [N];
    logic [RW-1:0] res_next [N];

    always_comb
    begin
        logic [RW-1:0] xp;
        logic [RW-1:0] rp;
        logic [RW-1:0] bt;
        xp = '0;
        rp = '0;
        bt = '0;
        for (int j = 0; j < N; j++)
        begin
            xp = (j == 0) ? RW'(x) : x_reg[(j == 0) ? 0 : j-1];
            rp = (j == 0) ? '0 : res_reg[(j == 0) ? 0 : j-1];
            bt = RW'(1) << (2 * (N - 1 - j));
            if (xp >= rp + bt)
            begin
                x_next[j]   = xp - rp - bt;
                res_next[j] = (rp >> 1) + bt;
            end
            else
            begin
                x_next[j]   = xp;
                res_next[j] = rp >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[N-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < N; j++)
        begin
            x_reg[j]   <= x_next[j];
            res_reg[j] <= res_next[j];
            mag_reg[j] <= (j == 0) ? in_mag : mag_reg[(j == 0) ? 0 : j-1];
            side_reg[j] <= (j == 0) ? in_side : side_reg[(j == 0) ? 0 : j-1];
        end
    end

    assign out_valid = vld_reg[N-1];
    assign root      = res_reg[N-1][ROOT_W-1:0];
    assign out_mag   = mag_reg[N-1];
    assign out_side  = side_reg[N-1];
endmodule
`default_nettype wire

### hdl/ppd_div.sv
// Three-lane pipelined restoring divider with rounding offset.
`default_nettype none
module ppd_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    input  ppd_pkg::mag3_t                  in_mag,
    input  wire logic [ppd_pkg::ROOT_W-1:0] root,
    input  ppd_pkg::side_t                  in_side,
    output logic                            out_valid,
    output ppd_pkg::quo3_t                  quo,
    output ppd_pkg::side_t                  out_side
);
    import ppd_pkg::*;

    logic                  vld0_reg;
    logic [2:0][NUM_W-1:0] num0_reg;
    logic [NUM_W-1:0]      den0_reg;
    side_t                 side0_reg;

    logic [QB-1:0]         vld_reg;
    logic [2:0][NUM_W-1:0] r_reg   [QB];
    quo3_t                 q_reg   [QB];
    logic [NUM_W-1:0]      den_reg [QB];
    side_t                 side_reg[QB];

    logic [2:0][NUM_W-1:0] r_next [QB];
    quo3_t                 q_next [QB];

    always_comb
    begin
        logic [NUM_W-1:0] d;
        logic [NUM_W-1:0] rp;
        logic [QB-1:0]    qp;
        d  = '0;
        rp = '0;
        qp = '0;
        for (int j = 0; j < QB; j++)
        begin
            d = ((j == 0) ? den0_reg : den_reg[(j == 0) ? 0 : j-1]) << (QB - 1 - j);
            for (int i = 0; i < 3; i++)
            begin
                rp = (j == 0) ? num0_reg[i] : r_reg[(j == 0) ? 0 : j-1][i];
                qp = (j == 0) ? '0 : q_reg[(j == 0) ? 0 : j-1][i];
                if (rp >= d)
                begin
                    r_next[j][i] = rp - d;
                    q_next[j][i] = qp | (QB'(1) << (QB - 1 - j));
                end
                else
                begin
                    r_next[j][i] = rp;
                    q_next[j][i] = qp;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld0_reg <= 1'b0;
            vld_reg  <= '0;
        end
        else
        begin
            vld0_reg <= in_valid;
            vld_reg  <= {vld_reg[QB-2:0], vld0_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            num0_reg[i] <= (NUM_W'(in_mag[i]) << (DIR_BITS - 1)) + NUM_W'(root >> 1);
        end
        den0_reg  <= NUM_W'(root);
        side0_reg <= in_side;
        for (int j = 0; j < QB; j++)
        begin
            r_reg[j]    <= r_next[j];
            q_reg[j]    <= q_next[j];
            den_reg[j]  <= (j == 0) ? den0_reg : den_reg[(j == 0) ? 0 : j-1];
            side_reg[j] <= (j == 0) ? side0_reg : side_reg[(j == 0) ? 0 : j-1];
        end
    end

    assign out_valid = vld_reg[QB-1];
    assign quo       = q_reg[QB-1];
    assign out_side  = side_reg[QB-1];
endmodule
`default_nettype wire

### hdl/pinhole_primary_ray_direction_unit.sv
// Top level: camera basis registers, ray direction pipeline and output saturation.
//
//  channel  signals                                    handshake
//  input    screen_u, screen_v                         start && !busy
//  result   dir_x, dir_y, dir_z, degenerate            done, one cycle
//  config   cfg_index, cfg_wdata                       cfg_we
//
// One transaction per clock; busy stays low and the receiver cannot stall.
// Each result passes, after its start, through 7 front stages,
// 31 square-root stages, 18 divider stages and the output register. The
// square-root and divider bit steps set the depth. Reset clears the basis
// registers and all valid bits.
`default_nettype none
module pinhole_primary_ray_direction_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic signed [ppd_pkg::COORD_BITS-1:0] screen_u,
    input  wire logic signed [ppd_pkg::COORD_BITS-1:0] screen_v,
    input  wire logic                              cfg_we,
    input  wire logic [ppd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [ppd_pkg::CFG_W-1:0]         cfg_wdata,
    output logic                                   done,
    output logic signed [ppd_pkg::DIR_BITS-1:0]    dir_x,
    output logic signed [ppd_pkg::DIR_BITS-1:0]    dir_y,
    output logic signed [ppd_pkg::DIR_BITS-1:0]    dir_z,
    output logic                                   degenerate
);
    import ppd_pkg::*;

    localparam logic [QB-1:0] HALF = QB'(1) << (DIR_BITS - 1);

    logic [CFG_W-1:0] right_reg;
    logic [CFG_W-1:0] up_reg;
    logic [CFG_W-1:0] fwd_reg;

    logic            f_valid;
    mag3_t           f_mag;
    logic [SQ_W-1:0] f_sumsq;
    side_t           f_side;

    logic              s_valid;
    logic [ROOT_W-1:0] s_root;
    mag3_t             s_mag;
    side_t             s_side;

    logic  d_valid;
    quo3_t d_quo;
    side_t d_side;

    logic                     done_reg;
    logic [2:0][DIR_BITS-1:0] dir_reg;
    logic                     degen_reg;
    logic [2:0][DIR_BITS-1:0] dir_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            right_reg <= '0;
            up_reg    <= '0;
            fwd_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                IDX_RIGHT: right_reg <= cfg_wdata;
                IDX_UP:    up_reg    <= cfg_wdata;
                IDX_FWD:   fwd_reg   <= cfg_wdata;
                default:   ;
            endcase
        end
    end

    assign busy = 1'b0;

    ppd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .u         (screen_u),
        .v         (screen_v),
        .right_cfg (right_reg),
        .up_cfg    (up_reg),
        .fwd_cfg   (fwd_reg),
        .out_valid (f_valid),
        .mag       (f_mag),
        .sumsq     (f_sumsq),
        .side      (f_side)
    );

    ppd_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .x         (f_sumsq),
        .in_mag    (f_mag),
        .in_side   (f_side),
        .out_valid (s_valid),
        .root      (s_root),
        .out_mag   (s_mag),
        .out_side  (s_side)
    );

    ppd_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_valid),
        .in_mag    (s_mag),
        .root      (s_root),
        .in_side   (s_side),
        .out_valid (d_valid),
        .quo       (d_quo),
        .out_side  (d_side)
    );

    always_comb
    begin
        logic [QB-1:0] qc;
        qc = '0;
        for (int i = 0; i < 3; i++)
        begin
            if (d_side.neg[i])
            begin
                qc = (d_quo[i] > HALF) ? HALF : d_quo[i];
                qc = -qc;
            end
            else
            begin
                qc = (d_quo[i] > HALF - QB'(1)) ? HALF - QB'(1) : d_quo[i];
            end
            dir_next[i] = d_side.degen ? '0 : qc[DIR_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= d_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        dir_reg   <= dir_next;
        degen_reg <= d_side.degen;
    end

    assign done       = done_reg;
    assign dir_x      = dir_reg[0];
    assign dir_y      = dir_reg[1];
    assign dir_z      = dir_reg[2];
    assign degenerate = degen_reg;

`ifndef SYNTHESIS
    a_latency : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result without a matching start");
    a_degen_zero : assert property (@(posedge clk) disable iff (!rst_n)
        done && degenerate |-> dir_x == '0 && dir_y == '0 && dir_z == '0)
        else $error("degenerate result with non-zero direction");
    a_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
        done && !degenerate |-> !(dir_x == '0 && dir_y == '0 && dir_z == '0))
        else $error("non-degenerate result with zero direction");
`endif
endmodule
`default_nettype wire
